/* rtl/weighted_least_connection_select_defines.svh */
// Assertion macros shared by the weighted least-connection selector.
`ifndef WEIGHTED_LEAST_CONNECTION_SELECT_DEFINES_SVH
`define WEIGHTED_LEAST_CONNECTION_SELECT_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define WLC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("weighted_least_connection_select: same-cycle check failed");

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define WLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("weighted_least_connection_select: next-cycle check failed");

`endif

/* rtl/wlc_pkg.sv */
// Shared constants, codes and types of the weighted least-connection selector.
package wlc_pkg;

  // Sizing of the slot table.
  localparam int NODES        = 8;
  localparam int COUNT_BITS   = 16;
  localparam int SLOT_W       = $clog2(NODES);
  localparam int STEP_W       = $clog2(NODES + 1);
  localparam int WEIGHT_BITS  = 8;
  localparam int WEIGHT_REGS  = 8;
  localparam int MASK_BITS    = 8;
  localparam int PROD_BITS    = COUNT_BITS + WEIGHT_BITS;

  // Stream field widths.
  localparam int CMD_W        = 2;
  localparam int SLOT_FIELD_W = 3;
  localparam int ERR_W        = 2;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 8;

  // Configuration port geometry.
  localparam int REG_IDX_W    = $clog2(WEIGHT_REGS);
  localparam int CFG_ADDR_W   = REG_IDX_W + 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(16);
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SELECT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STATUS  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_SLOT   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SATURATED = 2'd2;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd3;

  typedef logic [NODES-1:0][WEIGHT_BITS-1:0] weight_vec_t;

  // One result item as it leaves the sequencer.
  typedef struct packed {
    logic                    found;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [ERR_W-1:0]        err;
  } res_t;

endpackage

/* rtl/weighted_least_connection_select.sv */
// Weighted least-connection slot selector: one select, release or set-status
// command per input transfer, one result transfer per command. A select walks
// all NODES slots through a single cross-multiply comparator, one slot per
// cycle; the command is captured, the slots are scanned, the winner's count is
// updated and the result is handed to the output register. Release, set status
// and the unused command go through an execute state in place of scan and
// update. The input is not ready while a command is in progress; the output
// register lets the next command start while the previous result still waits to
// be taken. Weights are written through the configuration port at byte address
// 4*i for slot i and should only be changed while no command is in progress.
`include "weighted_least_connection_select_defines.svh"

module weighted_least_connection_select import wlc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // cmd[1:0], exclude_mask[9:2], slot_index[12:10], online_in[13], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // found[0], chosen_slot[3:1], err_code[5:4], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  weight_vec_t             weights;
  logic [CMD_W-1:0]        in_cmd;
  logic [MASK_BITS-1:0]    in_exclude_mask;
  logic [SLOT_FIELD_W-1:0] in_slot_index;
  logic                    in_online_in;
  logic                    res_valid;
  logic                    res_ready;
  res_t                    res;
  logic                    out_valid_r, out_valid_nxt;
  res_t                    out_res_r, out_res_nxt;

  // Unpack the input transfer.
  assign in_cmd          = in_tdata[1:0];
  assign in_exclude_mask = in_tdata[9:2];
  assign in_slot_index   = in_tdata[12:10];
  assign in_online_in    = in_tdata[13];

  wlc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .weights (weights)
  );

  wlc_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .cmd          (in_cmd),
    .exclude_mask (in_exclude_mask),
    .slot_index   (in_slot_index),
    .online_in    (in_online_in),
    .weights      (weights),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready)
  );

  // Output register: free when empty or when its result is taken this cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.err, out_res_r.slot, out_res_r.found};

  // A command in progress blocks the input until its result has been handed over.
  `WLC_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // A finished result waits in the sequencer, unchanged, until the output register frees.
  `WLC_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(res))
  // A grant is never reported together with an error.
  `WLC_ASSERT_IMPL(a_grant_is_ok, res_valid && res.found, res.err == ERR_OK)

endmodule

/* rtl/wlc_cfg_regs.sv */
// APB-style register file holding the per-slot weights.
module wlc_cfg_regs import wlc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output weight_vec_t           weights
);

  weight_vec_t            weights_r;
  weight_vec_t            weights_nxt;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   wr_en;
  logic [WEIGHT_BITS-1:0] rd_val;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // A write lands in the addressed weight; slots without a register keep the reset weight.
  always_comb begin
    weights_nxt = weights_r;
    for (int i = 0; i < NODES; i++) begin
      if (i < WEIGHT_REGS && wr_en && reg_idx == REG_IDX_W'(i)) begin
        weights_nxt[i] = pwdata[WEIGHT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r <= {NODES{WEIGHT_RESET}};
    end else begin
      weights_r <= weights_nxt;
    end
  end

  // Read back the addressed weight, zero where no slot sits behind the register.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < WEIGHT_REGS; i++) begin
      if (i < NODES && reg_idx == REG_IDX_W'(i)) begin
        rd_val = weights_r[i];
      end
    end
  end

  assign prdata  = CFG_DATA_W'(rd_val);
  assign weights = weights_r;

endmodule

/* rtl/wlc_ratio_cmp.sv */
// Shared cross-multiply comparator: is count_a/weight_a below count_b/weight_b.
module wlc_ratio_cmp import wlc_pkg::*; (
  input  logic [COUNT_BITS-1:0]  cnt_a,
  input  logic [WEIGHT_BITS-1:0] wgt_a,
  input  logic [COUNT_BITS-1:0]  cnt_b,
  input  logic [WEIGHT_BITS-1:0] wgt_b,
  output logic                   a_less
);

  logic [PROD_BITS-1:0] lhs;
  logic [PROD_BITS-1:0] rhs;

  // Both weights carry the same 4.4 scale, so the products compare exactly.
  assign lhs    = PROD_BITS'(cnt_a) * PROD_BITS'(wgt_b);
  assign rhs    = PROD_BITS'(cnt_b) * PROD_BITS'(wgt_a);
  assign a_less = lhs < rhs;

endmodule

/* rtl/wlc_seq.sv */
// Sequencer: slot state, the per-slot scan through the comparator, and command execution.
module wlc_seq import wlc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        cmd,
  input  logic [MASK_BITS-1:0]    exclude_mask,
  input  logic [SLOT_FIELD_W-1:0] slot_index,
  input  logic                    online_in,
  input  weight_vec_t             weights,
  output logic                    res_valid,
  output res_t                    res,
  input  logic                    res_ready
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_EXEC   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [CMD_W-1:0]            cmd_r, cmd_nxt;
  logic [MASK_BITS-1:0]        mask_r, mask_nxt;
  logic [SLOT_FIELD_W-1:0]     idx_r, idx_nxt;
  logic                        onl_r, onl_nxt;
  logic [NODES-1:0][COUNT_BITS-1:0] counts_r, counts_nxt;
  logic [NODES-1:0]            online_r, online_nxt;
  logic [SLOT_W-1:0]           ptr_r, ptr_nxt;
  logic [SLOT_W-1:0]           scan_r, scan_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic                        have_r, have_nxt;
  logic [SLOT_W-1:0]           best_r, best_nxt;
  logic [COUNT_BITS-1:0]       best_cnt_r, best_cnt_nxt;
  logic [WEIGHT_BITS-1:0]      best_wgt_r, best_wgt_nxt;
  res_t                        res_r, res_nxt;

  logic                        accept;
  logic                        idx_ok;
  logic [SLOT_W-1:0]           idx_slot;
  logic [SLOT_W-1:0]           rd_addr;
  logic [COUNT_BITS-1:0]       rd_cnt;
  logic [WEIGHT_BITS-1:0]      scan_wgt;
  logic [NODES-1:0]            mask_ext;
  logic                        eligible;
  logic                        scan_less;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  // Addressed slot of release and set status, and whether it exists.
  assign idx_ok   = int'(idx_r) < NODES;
  assign idx_slot = SLOT_W'(idx_r);

  // Single count read port: the scanned slot while scanning, else the addressed slot.
  assign rd_addr  = (state_r == ST_SCAN) ? scan_r : idx_slot;
  assign rd_cnt   = counts_r[rd_addr];
  assign scan_wgt = weights[scan_r];
  assign mask_ext = NODES'(mask_r);
  assign eligible = online_r[scan_r] && (scan_wgt != '0) && !mask_ext[scan_r];

  wlc_ratio_cmp u_cmp (
    .cnt_a  (rd_cnt),
    .wgt_a  (scan_wgt),
    .cnt_b  (best_cnt_r),
    .wgt_b  (best_wgt_r),
    .a_less (scan_less)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    mask_nxt     = mask_r;
    idx_nxt      = idx_r;
    onl_nxt      = onl_r;
    counts_nxt   = counts_r;
    online_nxt   = online_r;
    ptr_nxt      = ptr_r;
    scan_nxt     = scan_r;
    step_nxt     = step_r;
    have_nxt     = have_r;
    best_nxt     = best_r;
    best_cnt_nxt = best_cnt_r;
    best_wgt_nxt = best_wgt_r;
    res_nxt      = res_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt   = cmd;
          mask_nxt  = exclude_mask;
          idx_nxt   = slot_index;
          onl_nxt   = online_in;
          scan_nxt  = ptr_r;
          step_nxt  = '0;
          have_nxt  = 1'b0;
          state_nxt = (cmd == CMD_SELECT) ? ST_SCAN : ST_EXEC;
        end
      end

      // One slot per cycle, starting at the tie pointer; a tie keeps the earlier slot.
      ST_SCAN: begin
        if (eligible && (!have_r || scan_less)) begin
          have_nxt     = 1'b1;
          best_nxt     = scan_r;
          best_cnt_nxt = rd_cnt;
          best_wgt_nxt = scan_wgt;
        end
        scan_nxt = (scan_r == SLOT_W'(NODES - 1)) ? '0 : scan_r + SLOT_W'(1);
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(NODES - 1)) begin
          state_nxt = ST_UPDATE;
        end
      end

      // Grant the winner unless no slot is eligible or its count is already at the top.
      ST_UPDATE: begin
        if (!have_r) begin
          res_nxt = '{found: 1'b0, slot: '0, err: ERR_NO_SLOT};
        end else if (best_cnt_r == COUNT_MAX) begin
          res_nxt = '{found: 1'b0, slot: '0, err: ERR_SATURATED};
        end else begin
          counts_nxt[best_r] = best_cnt_r + COUNT_BITS'(1);
          ptr_nxt = (best_r == SLOT_W'(NODES - 1)) ? '0 : best_r + SLOT_W'(1);
          res_nxt = '{found: 1'b1, slot: SLOT_FIELD_W'(best_r), err: ERR_OK};
        end
        state_nxt = ST_DONE;
      end

      // Release, set status and the unused command.
      ST_EXEC: begin
        res_nxt = '{found: 1'b0, slot: '0, err: ERR_OK};
        case (cmd_r)
          CMD_RELEASE: begin
            if (idx_ok) begin
              if (rd_cnt == '0) begin
                res_nxt.err = ERR_UNDERFLOW;
              end else begin
                counts_nxt[idx_slot] = rd_cnt - COUNT_BITS'(1);
              end
            end
          end
          CMD_STATUS: begin
            if (idx_ok) begin
              online_nxt[idx_slot] = onl_r;
            end
          end
          default: begin
          end
        endcase
        state_nxt = ST_DONE;
      end

      // Hold the result until the output register can take it.
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and slot state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      counts_r <= '0;
      online_r <= '1;
      ptr_r    <= '0;
      have_r   <= 1'b0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      counts_r <= counts_nxt;
      online_r <= online_nxt;
      ptr_r    <= ptr_nxt;
      have_r   <= have_nxt;
      step_r   <= step_nxt;
    end
  end

  // Item payload and scan working registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    mask_r     <= mask_nxt;
    idx_r      <= idx_nxt;
    onl_r      <= onl_nxt;
    scan_r     <= scan_nxt;
    best_r     <= best_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_wgt_r <= best_wgt_nxt;
    res_r      <= res_nxt;
  end

endmodule

/* sim/tb.sv */
// Self-checking testbench for the weighted least-connection slot selector.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wlc_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 150;

  // Tracks the slot table and holds the replies still owed by the block.
  class wlc_slot_tracker;
    logic [WEIGHT_BITS-1:0] weight [NODES];
    logic [COUNT_BITS-1:0]  conn_count [NODES];
    bit                     online [NODES];
    int unsigned            tie_ptr;
    res_t                   expected_replies [$];
    int                     mismatches;

    function new();
      for (int i = 0; i < NODES; i++) begin
        weight[i]     = WEIGHT_RESET;
        conn_count[i] = '0;
        online[i]     = 1'b1;
      end
      tie_ptr    = 0;
      mismatches = 0;
    endfunction

    function void set_weight(int slot, logic [WEIGHT_BITS-1:0] value);
      if (slot < NODES && slot < WEIGHT_REGS)
        weight[slot] = value;
    endfunction

    // Works out the reply to one accepted command and updates the table.
    function void note_command(logic [CMD_W-1:0] cmd, logic [MASK_BITS-1:0] mask,
                               logic [SLOT_FIELD_W-1:0] idx, logic onl);
      res_t            reply;
      int              best;
      int              s;
      bit              have;
      longint unsigned lhs;
      longint unsigned rhs;
      reply = '0;
      best  = 0;
      have  = 1'b0;
      case (cmd)
        CMD_SELECT: begin
          // Scan from the tie pointer; only a strictly lower ratio displaces
          // the current best, so the first tied slot wins.
          for (int k = 0; k < NODES; k++) begin
            s = (tie_ptr + k) % NODES;
            if (online[s] && weight[s] != '0 && !(s < MASK_BITS && mask[s])) begin
              lhs = 64'(conn_count[s]) * 64'(weight[best]);
              rhs = 64'(conn_count[best]) * 64'(weight[s]);
              if (!have || lhs < rhs) begin
                best = s;
                have = 1'b1;
              end
            end
          end
          if (!have) begin
            reply.err = ERR_NO_SLOT;
          end else if (conn_count[best] == COUNT_MAX) begin
            reply.err = ERR_SATURATED;
          end else begin
            conn_count[best] = conn_count[best] + 1'b1;
            tie_ptr          = (best + 1) % NODES;
            reply.found      = 1'b1;
            reply.slot       = SLOT_FIELD_W'(best);
            reply.err        = ERR_OK;
          end
        end
        CMD_RELEASE: begin
          if (idx < NODES) begin
            if (conn_count[idx] == '0)
              reply.err = ERR_UNDERFLOW;
            else
              conn_count[idx] = conn_count[idx] - 1'b1;
          end
        end
        CMD_STATUS: begin
          if (idx < NODES)
            online[idx] = onl;
        end
        default: ;
      endcase
      expected_replies.push_back(reply);
    endfunction

    // Compares one result transfer with the oldest owed reply.
    function void compare_reply(logic [OUT_DATA_W-1:0] data);
      res_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: reply %02h arrived, expected none", $time, data);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      if (data[0] !== want.found) begin
        $display("%0t: found expected %0d, actual %0d", $time, want.found, data[0]);
        mismatches++;
      end
      if (data[3:1] !== want.slot) begin
        $display("%0t: chosen_slot expected %0d, actual %0d", $time, want.slot, data[3:1]);
        mismatches++;
      end
      if (data[5:4] !== want.err) begin
        $display("%0t: err_code expected %0d, actual %0d", $time, want.err, data[5:4]);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  // cmd[1:0], exclude_mask[9:2], slot_index[12:10], online_in[13], zero pad
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  // found[0], chosen_slot[3:1], err_code[5:4], zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;

  wlc_slot_tracker book = new();

  weighted_least_connection_select u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checking.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      book.compare_reply(out_tdata);
  end

  // Watchdog: any transfer on any port restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("weighted_least_connection_select regression: fail");
      $finish;
    end
  end

  // Offers one command and waits for its transfer. The valid is left high
  // afterwards; the next call or the drain decides what it becomes.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [MASK_BITS-1:0] mask,
                              logic [SLOT_FIELD_W-1:0] idx, logic onl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {2'b00, onl, idx, mask, cmd};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.note_command(cmd, mask, idx, onl);
  endtask

  // Stops offering commands and waits until every owed reply has come.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_weight(int slot, logic [WEIGHT_BITS-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'(slot * 4);
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    book.set_weight(slot, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // New weights for every slot, with zero, full scale and the smallest step favored.
  task automatic load_random_weights();
    int pick;
    for (int i = 0; i < WEIGHT_REGS; i++) begin
      pick = $urandom_range(9);
      case (pick)
        0:       write_weight(i, 8'd0);
        1:       write_weight(i, 8'd255);
        2:       write_weight(i, 8'd1);
        default: write_weight(i, WEIGHT_BITS'($urandom_range(1, 255)));
      endcase
    end
  endtask

  // Mostly selects and releases so counts move both ways; some status flips
  // and unused commands with random content.
  task automatic send_random_command();
    int                      r;
    int                      bit_pos;
    logic [MASK_BITS-1:0]    mask;
    logic [SLOT_FIELD_W-1:0] idx;
    logic                    onl;
    r       = $urandom_range(99);
    bit_pos = $urandom_range(MASK_BITS - 1);
    case ($urandom_range(9))
      0, 1, 2: mask = '0;
      3, 4, 5: mask = MASK_BITS'($urandom);
      6, 7:    mask = MASK_BITS'(1) << bit_pos;
      8:       mask = ~(MASK_BITS'(1) << bit_pos);
      default: mask = '1;
    endcase
    idx = SLOT_FIELD_W'($urandom_range(7));
    onl = 1'($urandom_range(1));
    if (r < 45) begin
      send_command(CMD_SELECT, mask, idx, onl);
    end else if (r < 75) begin
      send_command(CMD_RELEASE, mask, idx, onl);
    end else if (r < 88) begin
      send_command(CMD_STATUS, mask, idx, $urandom_range(9) < 7);
    end else begin
      send_command(CMD_NOP, mask, idx, onl);
    end
  endtask

  task automatic run_phase(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < ITEMS_PER_PHASE; n++)
      send_random_command();
    wait_drained();
    load_random_weights();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tie rotation, empty candidate set, underflow, offline slots.
    send_command(CMD_SELECT, 8'h00, 3'd0, 1'b0);
    send_command(CMD_SELECT, 8'h00, 3'd0, 1'b0);
    send_command(CMD_SELECT, 8'hFF, 3'd7, 1'b1);
    send_command(CMD_RELEASE, 8'h00, 3'd0, 1'b0);
    send_command(CMD_RELEASE, 8'h00, 3'd0, 1'b0);
    send_command(CMD_STATUS, 8'h00, 3'd3, 1'b0);
    send_command(CMD_SELECT, 8'hF7, 3'd0, 1'b0);
    send_command(CMD_STATUS, 8'h00, 3'd3, 1'b1);
    send_command(CMD_SELECT, 8'hF7, 3'd0, 1'b0);
    // A release of an offline slot still takes one connection off.
    send_command(CMD_SELECT, 8'hDF, 3'd0, 1'b0);
    send_command(CMD_STATUS, 8'h00, 3'd5, 1'b0);
    send_command(CMD_RELEASE, 8'h00, 3'd5, 1'b0);
    send_command(CMD_RELEASE, 8'h00, 3'd5, 1'b0);
    send_command(CMD_STATUS, 8'h00, 3'd5, 1'b1);
    send_command(CMD_NOP, 8'hFF, 3'd7, 1'b1);
    send_command(CMD_NOP, 8'h00, 3'd0, 1'b0);
    wait_drained();

    // Weight extremes: unused slot, full scale, smallest step.
    write_weight(0, 8'd0);
    write_weight(1, 8'd255);
    write_weight(2, 8'd1);
    write_weight(3, 8'h80);
    write_weight(7, 8'h0F);
    for (int n = 0; n < 5; n++)
      send_command(CMD_SELECT, 8'h00, 3'd0, 1'b0);
    send_command(CMD_SELECT, 8'hFE, 3'd0, 1'b0);
    send_command(CMD_SELECT, 8'h7C, 3'd0, 1'b0);
    wait_drained();
    load_random_weights();

    // Random traffic under the four idling schemes.
    run_phase(0, 0);
    run_phase(63, 0);
    run_phase(0, 63);
    run_phase(13, 13);

    // Unit weights again, then a short burst on one slot with the others masked.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < WEIGHT_REGS; i++)
      write_weight(i, WEIGHT_RESET);
    send_command(CMD_STATUS, 8'h00, 3'd6, 1'b1);
    for (int n = 0; n < 8; n++)
      send_command(CMD_SELECT, 8'hBF, 3'd0, 1'b0);
    send_command(CMD_SELECT, 8'h00, 3'd0, 1'b0);
    send_command(CMD_RELEASE, 8'h00, 3'd6, 1'b0);
    send_command(CMD_SELECT, 8'hBF, 3'd0, 1'b0);
    send_command(CMD_SELECT, 8'hBF, 3'd0, 1'b0);
    wait_drained();

    // Leave room for any stray result to show up.
    repeat (4 * (NODES + 3)) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("weighted_least_connection_select regression: pass");
    end else begin
      $display("weighted_least_connection_select regression: fail");
    end
    $finish;
  end

endmodule
